// File: sv/mcc_pkg.sv
// Shared types and constants for the Muskingum-Cunge coefficient pipeline.
// Used by the top level and the port checker; no dependencies.
`default_nettype none
package mcc_pkg;

    localparam int COEFF_FRAC_BITS_DEF = 16;
    localparam int COEFF_W             = 19;
    localparam int COURANT_W           = 32;
    localparam int DT_W                = 17;

    localparam logic [DT_W-1:0] DT_RESET = 17'd86400;

    // Size thresholds on the raw codes: 10 m, 0.1 m, 0.5 m, 0.001 m/s.
    localparam logic [23:0] LEN_MIN = 24'd160;
    localparam logic [17:0] DEP_MIN = 18'd102;
    localparam logic [19:0] WID_MIN = 20'd8;
    localparam logic [19:0] VEL_MIN = 20'd65;

    localparam logic [18:0] XI_BIAS   = 19'd12288;
    localparam logic [30:0] SLOPE_MIN = 31'd65536;
    localparam logic [47:0] D_SCALE   = 48'd3125;

    localparam logic [61:0] Q_CAP   = 62'h2000_0000_0000_0000;
    localparam logic [62:0] Q32_ONE = 63'h1_0000_0000;

    localparam int OUT_MAX = 262143;
    localparam int OUT_MIN = -262144;

    typedef struct packed {
        logic fail;
        logic len0;
    } mcc_flags_t;

    typedef struct packed {
        mcc_flags_t            flags;
        logic                  below_one;
        logic                  neg1;
        logic                  neg2;
        logic [COURANT_W-1:0]  courant;
    } mcc_coeff_side_t;

endpackage
`default_nettype wire

// File: sv/muskingum_coeff_calc.sv
// Muskingum-Cunge routing coefficients, one river cell per word, fully pipelined.
// Depends on mcc_pkg and mcc_div_pipe.
`default_nettype none
// The block takes one cell word per clock and returns one result word per cell,
// in order: four stages form the operands and the products, a 95-stage divider
// pipeline forms the Courant number C and the cell Reynolds number D side by side,
// two stages cap and combine them, a pipeline of COEFF_FRAC_BITS + 1 stages forms
// the three coefficients, and a final stage saturates and selects the fallback
// values. Sustained throughput is one word per cycle; every stage holds under
// stall, and the input is stalled only while the output register holds a word
// that the receiver has not taken. The time step register is sampled into the
// pipeline together with each cell, so writing it affects only cells accepted
// afterward. A cell that fails the size test (and has a zero shape exponent), a
// cell of zero length, or one with C + D below 1.0 gives C0 = 1.0, C1 = C2 = 0
// with used_fallback set; the Courant number is zero in the first case, saturated
// in the second and kept in the third.
module muskingum_coeff_calc #(
    parameter int COEFF_FRAC_BITS = mcc_pkg::COEFF_FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mcc_pkg::DT_W-1:0]      time_step_seconds,
    input  wire logic                          cell_valid,
    output logic                               cell_stall,
    input  wire logic [23:0]                   cell_length,
    input  wire logic [17:0]                   mean_depth,
    input  wire logic [19:0]                   mean_width,
    input  wire logic [19:0]                   mean_velocity,
    input  wire logic [15:0]                   shape_exponent,
    input  wire logic [23:0]                   bed_slope,
    output logic                               coeff_valid,
    input  wire logic                          coeff_stall,
    output logic signed [18:0]                 coeff_current_inflow,
    output logic signed [18:0]                 coeff_previous_inflow,
    output logic signed [18:0]                 coeff_previous_outflow,
    output logic [31:0]                        courant_number,
    output logic                               used_fallback
);
    import mcc_pkg::*;

    localparam int FQ_W = COEFF_FRAC_BITS + 1;
    localparam int BQ_W = 95;
    localparam int BD_W = 74;
    localparam int CD_W = 63;
    localparam int SIDE_W = $bits(mcc_coeff_side_t);
    localparam logic [COEFF_W-1:0] COEFF_ONE =
        ((2 ** COEFF_FRAC_BITS) > OUT_MAX) ? COEFF_W'(OUT_MAX) : COEFF_W'(2 ** COEFF_FRAC_BITS);

    // Truncated quotient with sign applied, clamped to the 19-bit signed range.
    function automatic logic [COEFF_W-1:0] sat_coeff(input logic [FQ_W-1:0] q, input logic neg);
        logic signed [31:0] v;
        v = signed'(32'(q));
        if (neg)
        begin
            v = -v;
        end
        if (v > 32'(OUT_MAX))
        begin
            v = 32'(OUT_MAX);
        end
        else if (v < 32'(OUT_MIN))
        begin
            v = 32'(OUT_MIN);
        end
        return v[COEFF_W-1:0];
    endfunction

    // The whole pipeline moves unless a finished word is waiting to be taken.
    logic advance;
    logic coeff_valid_reg;
    assign advance    = !(coeff_valid_reg && coeff_stall);
    assign cell_stall = !advance;

    // Time step register; always ready.
    logic [DT_W-1:0] dt_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg <= DT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            dt_reg <= time_step_seconds;
        end
    end

    // Stage A: threshold test, xi numerator and denominator, clamped slope.
    mcc_flags_t flags_a_next, flags_a_reg;
    logic        v_a_reg;
    logic [18:0] xn_a_next, xn_a_reg;
    logic [17:0] xd_a_next, xd_a_reg;
    logic [30:0] ss_a_next, ss_a_reg;
    logic [23:0] len_a_reg;
    logic [17:0] dep_a_reg;
    logic [19:0] vel_a_reg;
    logic [DT_W-1:0] dt_a_reg;
    logic sizes_ok;

    always_comb
    begin
        sizes_ok = (cell_length > LEN_MIN) && (mean_depth > DEP_MIN) &&
                   (mean_width > WID_MIN) && (mean_velocity > VEL_MIN);
        flags_a_next.fail = !(sizes_ok || (shape_exponent != 16'd0));
        flags_a_next.len0 = (cell_length == 24'd0);
        xn_a_next = 19'(shape_exponent) * 19'd5 + XI_BIAS;
        xd_a_next = 18'(shape_exponent) * 18'd3 + 18'(XI_BIAS);
        ss_a_next = 31'(bed_slope) * 31'd100;
        if (ss_a_next < SLOPE_MIN)
        begin
            ss_a_next = SLOPE_MIN;
        end
    end

    // Stage B: first products.
    mcc_flags_t  flags_b_reg;
    logic        v_b_reg;
    logic [38:0] m1_b_reg;
    logic [35:0] dx_b_reg;
    logic [54:0] lss_b_reg;
    logic [41:0] cden_b_reg;
    logic [18:0] xn_b_reg;
    logic [DT_W-1:0] dt_b_reg;

    // Stage C: second products; len*ss*xn is split into two partial products.
    mcc_flags_t  flags_c_reg;
    logic        v_c_reg;
    logic [55:0] cnum_c_reg;
    logic [47:0] dnum_c_reg;
    logic [46:0] ddl_c_reg;
    logic [45:0] ddh_c_reg;
    logic [41:0] cden_c_reg;

    // Stage D: D denominator assembled, dividends aligned.
    mcc_flags_t      flags_d_reg;
    logic            v_d_reg;
    logic [BQ_W-1:0] cbits_d_reg;
    logic [BQ_W-1:0] dbits_d_reg;
    logic [BD_W-1:0] cden_d_reg;
    logic [BD_W-1:0] dden_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
            v_d_reg <= 1'b0;
        end
        else if (advance)
        begin
            v_a_reg <= cell_valid;
            v_b_reg <= v_a_reg;
            v_c_reg <= v_b_reg;
            v_d_reg <= v_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            flags_a_reg <= flags_a_next;
            xn_a_reg    <= xn_a_next;
            xd_a_reg    <= xd_a_next;
            ss_a_reg    <= ss_a_next;
            len_a_reg   <= cell_length;
            dep_a_reg   <= mean_depth;
            vel_a_reg   <= mean_velocity;
            dt_a_reg    <= dt_reg;

            flags_b_reg <= flags_a_reg;
            m1_b_reg    <= 39'(xn_a_reg) * 39'(vel_a_reg);
            dx_b_reg    <= 36'(dep_a_reg) * 36'(xd_a_reg);
            lss_b_reg   <= 55'(len_a_reg) * 55'(ss_a_reg);
            cden_b_reg  <= 42'(xd_a_reg) * 42'(len_a_reg);
            xn_b_reg    <= xn_a_reg;
            dt_b_reg    <= dt_a_reg;

            flags_c_reg <= flags_b_reg;
            cnum_c_reg  <= 56'(m1_b_reg) * 56'(dt_b_reg);
            dnum_c_reg  <= 48'(dx_b_reg) * D_SCALE;
            ddl_c_reg   <= 47'(lss_b_reg[27:0]) * 47'(xn_b_reg);
            ddh_c_reg   <= 46'(lss_b_reg[54:28]) * 46'(xn_b_reg);
            cden_c_reg  <= cden_b_reg;

            flags_d_reg <= flags_c_reg;
            cbits_d_reg <= BQ_W'(cnum_c_reg) << 20;
            dbits_d_reg <= {dnum_c_reg, 47'd0};
            cden_d_reg  <= BD_W'(cden_c_reg);
            dden_d_reg  <= (BD_W'(ddh_c_reg) << 28) + BD_W'(ddl_c_reg);
        end
    end

    // C and D quotients, lane 0 is C and lane 1 is D.
    logic                      bdiv_valid;
    logic [1:0][BQ_W-1:0]      bdiv_quot;
    logic [$bits(mcc_flags_t)-1:0] bdiv_side;

    mcc_div_pipe #(
        .LANES  (2),
        .Q_W    (BQ_W),
        .D_W    (BD_W),
        .SIDE_W ($bits(mcc_flags_t))
    ) u_cd_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (v_d_reg),
        .rem_init      ({BD_W'(0), BD_W'(0)}),
        .den           ({dden_d_reg, cden_d_reg}),
        .dividend_bits ({dbits_d_reg, cbits_d_reg}),
        .in_side       (flags_d_reg),
        .out_valid     (bdiv_valid),
        .quotient      (bdiv_quot),
        .out_side      (bdiv_side)
    );

    // Stage E: cap both quotients at 2^61 and form the Courant output.
    logic [61:0] cq_e_next, dq_e_next, cq_e_reg, dq_e_reg;
    logic [31:0] courant_e_next, courant_e_reg;
    mcc_flags_t  flags_e_reg;
    logic        v_e_reg;

    always_comb
    begin
        if ((bdiv_quot[0][BQ_W-1:62] != '0) || (bdiv_quot[0][61] && (bdiv_quot[0][60:0] != '0)))
        begin
            cq_e_next = Q_CAP;
        end
        else
        begin
            cq_e_next = bdiv_quot[0][61:0];
        end
        if ((bdiv_quot[1][BQ_W-1:62] != '0) || (bdiv_quot[1][61] && (bdiv_quot[1][60:0] != '0)))
        begin
            dq_e_next = Q_CAP;
        end
        else
        begin
            dq_e_next = bdiv_quot[1][61:0];
        end
        if (cq_e_next[61:48] != '0)
        begin
            courant_e_next = '1;
        end
        else
        begin
            courant_e_next = cq_e_next[47:16];
        end
    end

    // Stage F: 1 + C + D and the three signed numerators.
    logic [CD_W-1:0] sum_f, den_f_reg, mag0_f_reg, mag1_f_reg, mag2_f_reg;
    logic [64:0]     d1_f, d2_f;
    logic            neg1_f_reg, neg2_f_reg, small_f_reg;
    logic [31:0]     courant_f_reg;
    mcc_flags_t      flags_f_reg;
    logic            v_f_reg;

    always_comb
    begin
        sum_f = CD_W'(cq_e_reg) + CD_W'(dq_e_reg);
        d1_f  = 65'(cq_e_reg) + 65'(Q32_ONE) - 65'(dq_e_reg);
        d2_f  = 65'(dq_e_reg) + 65'(Q32_ONE) - 65'(cq_e_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_e_reg <= 1'b0;
            v_f_reg <= 1'b0;
        end
        else if (advance)
        begin
            v_e_reg <= bdiv_valid;
            v_f_reg <= v_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cq_e_reg      <= cq_e_next;
            dq_e_reg      <= dq_e_next;
            courant_e_reg <= courant_e_next;
            flags_e_reg   <= bdiv_side;

            den_f_reg     <= sum_f + Q32_ONE;
            small_f_reg   <= (sum_f < Q32_ONE);
            mag0_f_reg    <= sum_f - Q32_ONE;
            neg1_f_reg    <= d1_f[64];
            neg2_f_reg    <= d2_f[64];
            mag1_f_reg    <= d1_f[64] ? CD_W'(-d1_f) : CD_W'(d1_f);
            mag2_f_reg    <= d2_f[64] ? CD_W'(-d2_f) : CD_W'(d2_f);
            courant_f_reg <= courant_e_reg;
            flags_f_reg   <= flags_e_reg;
        end
    end

    // Coefficient quotients: (mag << F) / (1 + C + D), each below 2^(F+1).
    mcc_coeff_side_t           side_f;
    logic                      fdiv_valid;
    logic [2:0][FQ_W-1:0]      fdiv_quot;
    logic [SIDE_W-1:0]         fdiv_side_raw;
    mcc_coeff_side_t           fdiv_side;

    always_comb
    begin
        side_f.flags     = flags_f_reg;
        side_f.below_one = small_f_reg;
        side_f.neg1      = neg1_f_reg;
        side_f.neg2      = neg2_f_reg;
        side_f.courant   = courant_f_reg;
    end

    mcc_div_pipe #(
        .LANES  (3),
        .Q_W    (FQ_W),
        .D_W    (CD_W),
        .SIDE_W (SIDE_W)
    ) u_coeff_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (v_f_reg),
        .rem_init      ({mag2_f_reg >> 1, mag1_f_reg >> 1, mag0_f_reg >> 1}),
        .den           ({den_f_reg, den_f_reg, den_f_reg}),
        .dividend_bits ({{mag2_f_reg[0], COEFF_FRAC_BITS'(0)},
                         {mag1_f_reg[0], COEFF_FRAC_BITS'(0)},
                         {mag0_f_reg[0], COEFF_FRAC_BITS'(0)}}),
        .in_side       (side_f),
        .out_valid     (fdiv_valid),
        .quotient      (fdiv_quot),
        .out_side      (fdiv_side_raw)
    );

    assign fdiv_side = fdiv_side_raw;

    // Stage G: output register, saturation and fallback selection.
    logic [COEFF_W-1:0] c0_reg, c1_reg, c2_reg;
    logic [COEFF_W-1:0] c0_next, c1_next, c2_next;
    logic [31:0]        courant_reg, courant_next;
    logic               fallback_reg, fallback_next;

    always_comb
    begin
        c0_next       = COEFF_ONE;
        c1_next       = '0;
        c2_next       = '0;
        fallback_next = 1'b1;
        courant_next  = fdiv_side.courant;
        if (fdiv_side.flags.fail)
        begin
            courant_next = '0;
        end
        else if (fdiv_side.flags.len0)
        begin
            courant_next = '1;
        end
        else if (!fdiv_side.below_one)
        begin
            c0_next       = sat_coeff(fdiv_quot[0], 1'b0);
            c1_next       = sat_coeff(fdiv_quot[1], fdiv_side.neg1);
            c2_next       = sat_coeff(fdiv_quot[2], fdiv_side.neg2);
            fallback_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            coeff_valid_reg <= fdiv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c0_reg       <= c0_next;
            c1_reg       <= c1_next;
            c2_reg       <= c2_next;
            courant_reg  <= courant_next;
            fallback_reg <= fallback_next;
        end
    end

    assign coeff_valid            = coeff_valid_reg;
    assign coeff_current_inflow   = c0_reg;
    assign coeff_previous_inflow  = c1_reg;
    assign coeff_previous_outflow = c2_reg;
    assign courant_number         = courant_reg;
    assign used_fallback          = fallback_reg;

endmodule
`default_nettype wire

// File: sv/mcc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage, several lanes in lockstep.
// Generic; carries a valid bit and a sideband word alongside. No package dependency.
`default_nettype none
module mcc_div_pipe #(
    parameter int LANES  = 1,
    parameter int Q_W    = 8,
    parameter int D_W    = 8,
    parameter int SIDE_W = 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic                          in_valid,
    input  wire logic [LANES-1:0][D_W-1:0]     rem_init,
    input  wire logic [LANES-1:0][D_W-1:0]     den,
    input  wire logic [LANES-1:0][Q_W-1:0]     dividend_bits,
    input  wire logic [SIDE_W-1:0]             in_side,
    output logic                               out_valid,
    output logic [LANES-1:0][Q_W-1:0]          quotient,
    output logic [SIDE_W-1:0]                  out_side
);

    logic                          valid_reg [Q_W];
    logic [LANES-1:0][D_W-1:0]     rem_reg   [Q_W];
    logic [LANES-1:0][D_W-1:0]     den_reg   [Q_W];
    logic [LANES-1:0][Q_W-1:0]     nq_reg    [Q_W];
    logic [SIDE_W-1:0]             side_reg  [Q_W];

    // Each stage shifts the top remaining dividend bit into the remainder and
    // shifts the new quotient bit in at the bottom of the same word.
    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic                      src_valid;
        logic [LANES-1:0][D_W-1:0] src_rem;
        logic [LANES-1:0][D_W-1:0] src_den;
        logic [LANES-1:0][Q_W-1:0] src_nq;
        logic [SIDE_W-1:0]         src_side;
        logic [LANES-1:0][D_W-1:0] rem_next;
        logic [LANES-1:0][Q_W-1:0] nq_next;

        if (s == 0) begin : g_first
            assign src_valid = in_valid;
            assign src_rem   = rem_init;
            assign src_den   = den;
            assign src_nq    = dividend_bits;
            assign src_side  = in_side;
        end else begin : g_rest
            assign src_valid = valid_reg[s-1];
            assign src_rem   = rem_reg[s-1];
            assign src_den   = den_reg[s-1];
            assign src_nq    = nq_reg[s-1];
            assign src_side  = side_reg[s-1];
        end

        always_comb
        begin
            logic [D_W:0] t;
            logic         qb;
            for (int l = 0; l < LANES; l++)
            begin
                t  = {src_rem[l], src_nq[l][Q_W-1]};
                qb = (t >= {1'b0, src_den[l]});
                if (qb)
                begin
                    t = t - {1'b0, src_den[l]};
                end
                rem_next[l] = t[D_W-1:0];
                nq_next[l]  = {src_nq[l][Q_W-2:0], qb};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[s] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= src_den;
                nq_reg[s]   <= nq_next;
                side_reg[s] <= src_side;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quotient  = nq_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule
`default_nettype wire

// File: sv/mcc_checker.sv
// Port-level checker for the coefficient block, bound to the top level.
// Depends on mcc_pkg and the top level's ports.
`default_nettype none
module mcc_checker #(
    parameter int FRAC = mcc_pkg::COEFF_FRAC_BITS_DEF
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cell_stall,
    input wire logic        coeff_valid,
    input wire logic        coeff_stall,
    input wire logic [18:0] coeff_current_inflow,
    input wire logic [18:0] coeff_previous_inflow,
    input wire logic [18:0] coeff_previous_outflow,
    input wire logic        used_fallback
);
    import mcc_pkg::*;

    localparam logic [COEFF_W-1:0] ONE =
        ((2 ** FRAC) > OUT_MAX) ? COEFF_W'(OUT_MAX) : COEFF_W'(2 ** FRAC);

    // A word held at the output stays until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        coeff_valid && coeff_stall |=> coeff_valid)
        else $error("result word dropped while stalled");

    // With the output register empty the pipeline must accept.
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !coeff_valid |-> !cell_stall)
        else $error("input stalled with empty output");

    // Fallback words carry 1, 0, 0.
    a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        coeff_valid && used_fallback |->
            coeff_current_inflow == ONE && coeff_previous_inflow == '0 &&
            coeff_previous_outflow == '0)
        else $error("fallback word with wrong coefficients");

    // C + D of at least one never gives a negative C0.
    a_c0_sign: assert property (@(posedge clk) disable iff (!rst_n)
        coeff_valid && !used_fallback |-> !coeff_current_inflow[18])
        else $error("negative C0 without fallback");

endmodule

bind muskingum_coeff_calc mcc_checker #(.FRAC(COEFF_FRAC_BITS)) u_mcc_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cell_stall             (cell_stall),
    .coeff_valid            (coeff_valid),
    .coeff_stall            (coeff_stall),
    .coeff_current_inflow   (coeff_current_inflow),
    .coeff_previous_inflow  (coeff_previous_inflow),
    .coeff_previous_outflow (coeff_previous_outflow),
    .used_fallback          (used_fallback)
);
`default_nettype wire
